// ===== rtl/circular_buffer_deque_unit_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the circular buffer deque unit
// Shared clocked assertion forms, sampled on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef CIRCULAR_BUFFER_DEQUE_UNIT_MACROS_SVH
`define CIRCULAR_BUFFER_DEQUE_UNIT_MACROS_SVH

// property holds at every edge outside reset
`define CBDQ_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define CBDQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/cbdq_pkg.sv =====
// ---------------------------------------------------------------------------
// Circular buffer deque package
// Sizes, codes, control structs and pointer helpers.
// ---------------------------------------------------------------------------
package cbdq_pkg;

    localparam int DEPTH     = 16;
    localparam int PTR_W     = $clog2(DEPTH);
    localparam int CNT_W     = $clog2(DEPTH + 1);
    localparam int CAP_W     = 5;
    localparam int CAP_RESET = 16;
    localparam int ACT_W     = 3;
    localparam int WORD_W    = 32;
    localparam int STAT_W    = 2;
    localparam int OUT_CNT_W = 5;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 112;

    localparam logic [ACT_W-1:0] ACT_PUSH_FRONT = 3'd0;
    localparam logic [ACT_W-1:0] ACT_PUSH_BACK  = 3'd1;
    localparam logic [ACT_W-1:0] ACT_POP_FRONT  = 3'd2;
    localparam logic [ACT_W-1:0] ACT_POP_BACK   = 3'd3;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic exec;      // run the accepted item
        logic rd_pop;    // read the popped slot
        logic rd_ends;   // read front and back slots
        logic load_out;  // load the result register
    } cmd_t;

    typedef struct packed {
        logic pop_ok;    // item on the input would pop a word
    } sts_t;

    function automatic logic [CNT_W-1:0] eff_cap(input logic [CAP_W-1:0] v);
        logic [CNT_W-1:0] r;
        if (v == '0)
            r = CNT_W'(1);
        else if (32'(v) > 32'(DEPTH))
            r = CNT_W'(DEPTH);
        else
            r = CNT_W'(v);
        return r;
    endfunction

    function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] x,
                                                  input logic [CNT_W-1:0] cap);
        logic [PTR_W-1:0] r;
        if (CNT_W'(x) + CNT_W'(1) == cap)
            r = '0;
        else
            r = PTR_W'(x + PTR_W'(1));
        return r;
    endfunction

    function automatic logic [PTR_W-1:0] wrap_dec(input logic [PTR_W-1:0] x,
                                                  input logic [CNT_W-1:0] cap);
        logic [PTR_W-1:0] r;
        if (x == '0)
            r = PTR_W'(cap - CNT_W'(1));
        else
            r = PTR_W'(x - PTR_W'(1));
        return r;
    endfunction

    function automatic logic [PTR_W-1:0] tail_init(input logic [CNT_W-1:0] cap);
        logic [PTR_W-1:0] r;
        if (cap == CNT_W'(1))
            r = '0;
        else
            r = PTR_W'(1);
        return r;
    endfunction

endpackage

// ===== rtl/circular_buffer_deque_unit.sv =====
// ---------------------------------------------------------------------------
// Circular buffer deque unit
// Double-ended queue of signed words in a circular slot store.
// ---------------------------------------------------------------------------
//  channel   direction  handshake                      payload
//  s_axis    in         s_axis_tvalid / s_axis_tready  action, push_value
//  m_axis    out        m_axis_tvalid / m_axis_tready  result fields
//  cfg       in         cfg_valid / cfg_ready          capacity
//
//  Each item is accepted and updated, then its front and back slots are read,
//  then the result is loaded; the slot RAM reads are registered.
//  Reset: capacity 16, queue empty; slot contents are not cleared.
//  A held result stalls the next item in S_FIN; s_axis_tready stays low
//  until that item is loaded into the result register.
//  Capacity writes are always taken and empty the queue.
// ---------------------------------------------------------------------------
module circular_buffer_deque_unit (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // [2:0] action, [34:3] push_value, [39:35] zero
    input  logic [cbdq_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // [31:0] popped_value, [33:32] status, [38:34] count, [39] is_empty,
    // [40] is_full, [72:41] head_value, [104:73] tail_value, [111:105] zero
    output logic [cbdq_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [cbdq_pkg::CAP_W-1:0]           cfg_data
);

    import cbdq_pkg::*;

    cmd_t              cmd;
    sts_t              sts;
    logic signed [WORD_W-1:0] popped_value, head_value, tail_value;
    logic [STAT_W-1:0]        status;
    logic [OUT_CNT_W-1:0]     count;
    logic                     is_empty, is_full;

    assign cfg_ready = 1'b1;

    cbdq_ctl u_ctl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .sts       (sts),
        .cmd       (cmd)
    );

    cbdq_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .in_action     (s_axis_tdata[2:0]),
        .in_push_value ($signed(s_axis_tdata[34:3])),
        .cfg_we        (cfg_valid),
        .cfg_capacity  (cfg_data),
        .popped_value  (popped_value),
        .status        (status),
        .count         (count),
        .is_empty      (is_empty),
        .is_full       (is_full),
        .head_value    (head_value),
        .tail_value    (tail_value)
    );

    assign m_axis_tdata = {7'd0, tail_value, head_value, is_full, is_empty,
                           count, status, popped_value};

endmodule

// ===== rtl/cbdq_ram.sv =====
// ---------------------------------------------------------------------------
// Generic RAM
// One write port, two read ports with registered read data.
// ---------------------------------------------------------------------------
module cbdq_ram #(
    parameter int WIDTH   = 32,
    parameter int ENTRIES = 16
) (
    input  logic                       clk,
    input  logic                       we,
    input  logic [$clog2(ENTRIES)-1:0] waddr,
    input  logic [WIDTH-1:0]           wdata,
    input  logic                       re_a,
    input  logic [$clog2(ENTRIES)-1:0] raddr_a,
    output logic [WIDTH-1:0]           rdata_a,
    input  logic                       re_b,
    input  logic [$clog2(ENTRIES)-1:0] raddr_b,
    output logic [WIDTH-1:0]           rdata_b
);

    logic [WIDTH-1:0] mem [ENTRIES];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re_a)
        begin
            rdata_a <= mem[raddr_a];
        end
        if (re_b)
        begin
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

// ===== rtl/cbdq_dp.sv =====
// ---------------------------------------------------------------------------
// Circular buffer deque datapath
// Pointers, count, capacity, slot store and result register.
// ---------------------------------------------------------------------------
`include "circular_buffer_deque_unit_macros.svh"

module cbdq_dp (
    input  logic                                clk,
    input  logic                                rst_n,
    input  cbdq_pkg::cmd_t                      cmd,
    output cbdq_pkg::sts_t                      sts,
    input  logic [cbdq_pkg::ACT_W-1:0]          in_action,
    input  logic signed [cbdq_pkg::WORD_W-1:0]  in_push_value,
    input  logic                                cfg_we,
    input  logic [cbdq_pkg::CAP_W-1:0]          cfg_capacity,
    output logic signed [cbdq_pkg::WORD_W-1:0]  popped_value,
    output logic [cbdq_pkg::STAT_W-1:0]         status,
    output logic [cbdq_pkg::OUT_CNT_W-1:0]      count,
    output logic                                is_empty,
    output logic                                is_full,
    output logic signed [cbdq_pkg::WORD_W-1:0]  head_value,
    output logic signed [cbdq_pkg::WORD_W-1:0]  tail_value
);

    import cbdq_pkg::*;

    logic [CNT_W-1:0]  cap_reg,   cap_next;
    logic [PTR_W-1:0]  head_reg,  head_next;
    logic [PTR_W-1:0]  tail_reg,  tail_next;
    logic [CNT_W-1:0]  cnt_reg,   cnt_next;
    logic [STAT_W-1:0] stat_reg,  stat_next;
    logic              pop_ok_reg;
    logic [WORD_W-1:0] popped_reg;

    logic [CNT_W-1:0]  cfg_cap;
    logic              is_push, is_pop, push_ok, pop_ok;
    logic              we;
    logic [PTR_W-1:0]  waddr, pop_addr, ra_addr;
    logic [WORD_W-1:0] rdata_a, rdata_b;

    assign cfg_cap = eff_cap(cfg_capacity);

    assign is_push = (in_action == ACT_PUSH_FRONT) || (in_action == ACT_PUSH_BACK);
    assign is_pop  = (in_action == ACT_POP_FRONT)  || (in_action == ACT_POP_BACK);
    assign push_ok = is_push && (cnt_reg < cap_reg);
    assign pop_ok  = is_pop && (cnt_reg != '0);
    assign sts.pop_ok = pop_ok;

    always_comb
    begin
        cap_next  = cap_reg;
        head_next = head_reg;
        tail_next = tail_reg;
        cnt_next  = cnt_reg;
        stat_next = stat_reg;
        we        = 1'b0;
        waddr     = head_reg;
        pop_addr  = wrap_inc(head_reg, cap_reg);
        if (in_action == ACT_POP_BACK)
        begin
            pop_addr = wrap_dec(tail_reg, cap_reg);
        end
        priority if (cfg_we)
        begin
            cap_next  = cfg_cap;
            head_next = '0;
            tail_next = tail_init(cfg_cap);
            cnt_next  = '0;
        end
        else if (cmd.exec)
        begin
            stat_next = ST_OK;
            if (is_push && !push_ok)
            begin
                stat_next = ST_FULL;
            end
            else if (is_pop && !pop_ok)
            begin
                stat_next = ST_EMPTY;
            end
            else if (in_action == ACT_PUSH_FRONT)
            begin
                we        = 1'b1;
                waddr     = head_reg;
                head_next = wrap_dec(head_reg, cap_reg);
                cnt_next  = CNT_W'(cnt_reg + CNT_W'(1));
            end
            else if (in_action == ACT_PUSH_BACK)
            begin
                we        = 1'b1;
                waddr     = tail_reg;
                tail_next = wrap_inc(tail_reg, cap_reg);
                cnt_next  = CNT_W'(cnt_reg + CNT_W'(1));
            end
            else if (in_action == ACT_POP_FRONT)
            begin
                head_next = pop_addr;
                cnt_next  = CNT_W'(cnt_reg - CNT_W'(1));
            end
            else if (in_action == ACT_POP_BACK)
            begin
                tail_next = pop_addr;
                cnt_next  = CNT_W'(cnt_reg - CNT_W'(1));
            end
        end
        else
        begin
            // no write and no item: hold
        end
    end

    assign ra_addr = cmd.rd_ends ? wrap_inc(head_reg, cap_reg) : pop_addr;

    cbdq_ram #(
        .WIDTH   (WORD_W),
        .ENTRIES (DEPTH)
    ) u_ram (
        .clk     (clk),
        .we      (we),
        .waddr   (waddr),
        .wdata   (in_push_value),
        .re_a    (cmd.rd_pop || cmd.rd_ends),
        .raddr_a (ra_addr),
        .rdata_a (rdata_a),
        .re_b    (cmd.rd_ends),
        .raddr_b (wrap_dec(tail_reg, cap_reg)),
        .rdata_b (rdata_b)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg    <= eff_cap(CAP_W'(CAP_RESET));
            head_reg   <= '0;
            tail_reg   <= tail_init(eff_cap(CAP_W'(CAP_RESET)));
            cnt_reg    <= '0;
            stat_reg   <= ST_OK;
            pop_ok_reg <= 1'b0;
        end
        else
        begin
            cap_reg  <= cap_next;
            head_reg <= head_next;
            tail_reg <= tail_next;
            cnt_reg  <= cnt_next;
            stat_reg <= stat_next;
            if (cmd.exec)
            begin
                pop_ok_reg <= pop_ok;
            end
        end
    end

    // popped word lands on port A the cycle after the item runs
    always_ff @(posedge clk)
    begin
        if (cmd.rd_ends)
        begin
            popped_reg <= pop_ok_reg ? rdata_a : '0;
        end
        if (cmd.load_out)
        begin
            popped_value <= $signed(popped_reg);
            status       <= stat_reg;
            count        <= OUT_CNT_W'(cnt_reg);
            is_empty     <= (cnt_reg == '0);
            is_full      <= (cnt_reg == cap_reg);
            head_value   <= (cnt_reg == '0) ? '0 : $signed(rdata_a);
            tail_value   <= (cnt_reg == '0) ? '0 : $signed(rdata_b);
        end
    end

    `CBDQ_ASSERT(a_cnt_in_cap, cnt_reg <= cap_reg, "count above capacity")
    `CBDQ_ASSERT(a_head_in_cap, CNT_W'(head_reg) < cap_reg, "head pointer out of range")
    `CBDQ_ASSERT(a_tail_in_cap, CNT_W'(tail_reg) < cap_reg, "tail pointer out of range")
    `CBDQ_ASSERT_NEXT(a_push_count, cmd.exec && push_ok && !cfg_we,
        cnt_reg == CNT_W'($past(cnt_reg) + CNT_W'(1)), "push did not raise count")

endmodule

// ===== rtl/cbdq_ctl.sv =====
// ---------------------------------------------------------------------------
// Circular buffer deque controller
// Sequences accept, slot reads and result hand-off.
// ---------------------------------------------------------------------------
module cbdq_ctl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    output logic           out_valid,
    input  logic           out_ready,
    input  cbdq_pkg::sts_t sts,
    output cbdq_pkg::cmd_t cmd
);

    import cbdq_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ENDS,
        S_FIN
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd.exec     = (state_reg == S_IDLE) && in_valid;
        cmd.rd_pop   = cmd.exec && sts.pop_ok;
        cmd.rd_ends  = (state_reg == S_ENDS);
        cmd.load_out = (state_reg == S_FIN) && (!out_valid_reg || out_ready);

        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_ENDS;
                end
            end
            S_ENDS:
            begin
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (cmd.load_out)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== tb/sv/circular_buffer_deque_unit_tb.sv =====
// ---------------------------------------------------------------------------
// Circular buffer deque unit testbench
// Drives push, pop and peek requests at both ends of the deque over several
// capacity settings and compares every result item, field by field, with an
// in-bench model of the queue. Sender and receiver idle at random.
// ---------------------------------------------------------------------------
module circular_buffer_deque_unit_tb;

    import cbdq_pkg::*;

    localparam logic [ACT_W-1:0] ACT_PEEK   = 3'd4;
    localparam logic [ACT_W-1:0] ACT_SPARE5 = 3'd5;
    localparam logic [ACT_W-1:0] ACT_SPARE6 = 3'd6;
    localparam logic [ACT_W-1:0] ACT_SPARE7 = 3'd7;

    typedef struct {
        logic [WORD_W-1:0]    popped;
        logic [STAT_W-1:0]    status;
        logic [OUT_CNT_W-1:0] count;
        logic                 empty;
        logic                 full;
        logic [WORD_W-1:0]    head_word;
        logic [WORD_W-1:0]    tail_word;
    } deque_result_t;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       s_axis_tvalid = 1'b0;
    logic                       s_axis_tready;
    logic [IN_TDATA_W-1:0]      s_axis_tdata = '0;
    logic                       m_axis_tvalid;
    logic                       m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0]     m_axis_tdata;
    logic                       cfg_valid = 1'b0;
    logic                       cfg_ready;
    logic [CAP_W-1:0]           cfg_data = '0;

    // queue model
    logic [WORD_W-1:0] slot_copy [DEPTH];
    int unsigned       front_gap = 0;
    int unsigned       back_gap = 1;
    int unsigned       stored = 0;
    logic [CAP_W-1:0]  cap_setting = CAP_W'(CAP_RESET);

    deque_result_t results_due [$];
    int            errors = 0;
    int            tx_idle_pct = 0;
    int            rx_idle_pct = 0;

    circular_buffer_deque_unit u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
        m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);

    function automatic int unsigned active_slots();
        int unsigned c;
        c = 32'(cap_setting);
        if (c == 0)
            c = 1;
        if (c > DEPTH)
            c = DEPTH;
        return c;
    endfunction

    function automatic void predict_request(input logic [ACT_W-1:0] act,
                                            input logic [WORD_W-1:0] word);
        deque_result_t r;
        int unsigned   lim;
        lim = active_slots();
        r = '{default: '0};
        r.status = ST_OK;
        front_gap = front_gap % lim;
        back_gap = back_gap % lim;
        case (act)
            ACT_PUSH_FRONT, ACT_PUSH_BACK:
            begin
                if (stored >= lim)
                    r.status = ST_FULL;
                else if (act == ACT_PUSH_FRONT)
                begin
                    slot_copy[front_gap] = word;
                    front_gap = (front_gap + lim - 1) % lim;
                    stored++;
                end
                else
                begin
                    slot_copy[back_gap] = word;
                    back_gap = (back_gap + 1) % lim;
                    stored++;
                end
            end
            ACT_POP_FRONT, ACT_POP_BACK:
            begin
                if (stored == 0)
                    r.status = ST_EMPTY;
                else if (act == ACT_POP_FRONT)
                begin
                    front_gap = (front_gap + 1) % lim;
                    r.popped = slot_copy[front_gap];
                    stored--;
                end
                else
                begin
                    back_gap = (back_gap + lim - 1) % lim;
                    r.popped = slot_copy[back_gap];
                    stored--;
                end
            end
            default: ;
        endcase
        r.count = OUT_CNT_W'(stored);
        r.empty = (stored == 0);
        r.full = (stored == lim);
        if (stored != 0)
        begin
            r.head_word = slot_copy[(front_gap + 1) % lim];
            r.tail_word = slot_copy[(back_gap + lim - 1) % lim];
        end
        results_due.push_back(r);
    endfunction

    task automatic check_field(input string fname, input logic [WORD_W-1:0] want,
                               input logic [WORD_W-1:0] got);
        if (want !== got)
        begin
            errors++;
            if (errors < 40)
                $display("%0t: %s mismatch, expected %h, actual %h",
                         $time, fname, want, got);
        end
    endtask

    always @(posedge clk)
    begin : result_check
        deque_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (results_due.size() == 0)
            begin
                errors++;
                if (errors < 40)
                    $display("%0t: unexpected result item, expected none, actual %h",
                             $time, m_axis_tdata);
            end
            else
            begin
                want = results_due.pop_front();
                check_field("popped_value", want.popped, m_axis_tdata[31:0]);
                check_field("status", WORD_W'(want.status),
                            WORD_W'(m_axis_tdata[33:32]));
                check_field("count", WORD_W'(want.count),
                            WORD_W'(m_axis_tdata[38:34]));
                check_field("is_empty", WORD_W'(want.empty),
                            WORD_W'(m_axis_tdata[39]));
                check_field("is_full", WORD_W'(want.full),
                            WORD_W'(m_axis_tdata[40]));
                check_field("head_value", want.head_word, m_axis_tdata[72:41]);
                check_field("tail_value", want.tail_word, m_axis_tdata[104:73]);
            end
        end
    end

    task automatic issue_request(input logic [ACT_W-1:0] act,
                                 input logic [WORD_W-1:0] word);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {5'd0, word, act};
        do
            @(posedge clk);
        while (!s_axis_tready);
        predict_request(act, word);
    endtask

    // hold off the sender until every result is back
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (results_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_capacity(input logic [CAP_W-1:0] v);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        cap_setting = v;
        front_gap = 0;
        back_gap = 1 % active_slots();
        stored = 0;
    endtask

    function automatic logic [WORD_W-1:0] pick_word();
        logic [WORD_W-1:0] w;
        case ($urandom_range(7))
            0: w = 32'h8000_0000;
            1: w = 32'h7fff_ffff;
            2: w = 32'h0000_0000;
            3: w = 32'hffff_ffff;
            default: w = $urandom;
        endcase
        return w;
    endfunction

    task automatic test_empty_access();
        issue_request(ACT_PEEK, 32'h0);
        issue_request(ACT_POP_FRONT, 32'hffff_ffff);
        issue_request(ACT_POP_BACK, 32'h0);
    endtask

    task automatic test_both_ends();
        issue_request(ACT_PUSH_FRONT, 32'h8000_0000);
        issue_request(ACT_PUSH_BACK, 32'h7fff_ffff);
        issue_request(ACT_PUSH_FRONT, 32'hffff_ffff);
        issue_request(ACT_PUSH_BACK, 32'h0000_0000);
        issue_request(ACT_PEEK, 32'h5a5a_a5a5);
        issue_request(ACT_POP_FRONT, 32'h0);
        issue_request(ACT_POP_BACK, 32'h0);
        issue_request(ACT_POP_BACK, 32'h0);
        issue_request(ACT_POP_FRONT, 32'h0);
        issue_request(ACT_POP_FRONT, 32'h0);
    endtask

    // spare action codes behave as a peek
    task automatic test_spare_actions();
        issue_request(ACT_PUSH_BACK, 32'h1234_5678);
        issue_request(ACT_SPARE5, 32'hffff_ffff);
        issue_request(ACT_SPARE6, 32'hffff_ffff);
        issue_request(ACT_SPARE7, 32'hffff_ffff);
        issue_request(ACT_POP_BACK, 32'h0);
    endtask

    task automatic test_capacity_edges();
        drain_results();
        set_capacity(5'd0);
        issue_request(ACT_PUSH_BACK, 32'hdead_beef);
        issue_request(ACT_PUSH_FRONT, 32'h0bad_f00d);
        issue_request(ACT_POP_FRONT, 32'h0);
        issue_request(ACT_POP_BACK, 32'h0);
        drain_results();
        set_capacity(5'd2);
        issue_request(ACT_PUSH_FRONT, 32'h8000_0000);
        issue_request(ACT_PUSH_BACK, 32'h7fff_ffff);
        issue_request(ACT_PUSH_BACK, 32'h1111_1111);
        issue_request(ACT_POP_BACK, 32'h0);
        issue_request(ACT_POP_FRONT, 32'h0);
    endtask

    // bursts lean towards filling or draining so both limits are reached
    task automatic test_random_traffic(input logic [CAP_W-1:0] cap_val,
                                       input int n_items);
        int               push_pct;
        int               roll;
        logic [ACT_W-1:0] act;
        drain_results();
        set_capacity(cap_val);
        push_pct = 50;
        for (int i = 0; i < n_items; i++)
        begin
            if (i % 20 == 0)
                case ($urandom_range(2))
                    0: push_pct = 80;
                    1: push_pct = 50;
                    default: push_pct = 20;
                endcase
            roll = $urandom_range(99);
            if (roll < 4)
                act = ACT_PEEK;
            else if (roll < 7)
                act = ACT_W'($urandom_range(ACT_SPARE5, ACT_SPARE7));
            else if ($urandom_range(99) < push_pct)
                act = $urandom_range(1) ? ACT_PUSH_BACK : ACT_PUSH_FRONT;
            else
                act = $urandom_range(1) ? ACT_POP_BACK : ACT_POP_FRONT;
            issue_request(act, pick_word());
        end
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        tx_idle_pct = 12;
        rx_idle_pct = 45;
        test_empty_access();
        test_both_ends();
        test_spare_actions();
        test_capacity_edges();
        test_random_traffic(5'd16, 200);
        test_random_traffic(5'd1, 60);
        test_random_traffic(5'd5, 100);

        tx_idle_pct = 45;
        rx_idle_pct = 12;
        test_random_traffic(5'd0, 40);
        test_random_traffic(5'd31, 150);
        test_random_traffic(5'd7, 100);

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        test_random_traffic(5'd16, 200);
        test_random_traffic(5'd3, 100);
        test_random_traffic(5'd17, 80);

        drain_results();
        repeat (10) @(posedge clk);
        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
